/* sv/ifp_pkg.sv */
package ifp_pkg;

    // Fixed IPv4 header size and limits used by the planner.
    localparam logic [15:0] HDR_BYTES   = 16'd20;
    localparam logic [15:0] MIN_MTU     = 16'd28;
    localparam logic [15:0] MTU_RESET   = 16'd1500;
    localparam logic [15:0] ALIGN_MASK  = 16'hFFF8;

    // Command codes of an input word.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BCAST_BIG = 3'd1,
        ST_DF_SET    = 3'd2,
        ST_MTU_SMALL = 3'd3,
        ST_NONE      = 3'd4
    } status_t;

    // One input word.
    typedef struct packed {
        logic        cmd;
        logic [15:0] total_len;
        logic        dont_fragment;
        logic        more_in;
        logic [12:0] offset_in;
        logic        forwarding;
        logic        broadcast;
        logic [15:0] ident_in;
    } in_word_t;

    // One result word.
    typedef struct packed {
        status_t     status;
        logic [15:0] frag_len;
        logic [12:0] frag_offset;
        logic        more_out;
        logic [15:0] ident_out;
        logic        last;
    } out_word_t;

    // Planner state visible to the top level.
    typedef struct packed {
        logic        pending;
        logic [15:0] id_count;
    } core_stat_t;

endpackage

/* sv/ifp_in_if.sv */
interface ifp_in_if
    import ifp_pkg::*;
;
    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/ifp_out_if.sv */
interface ifp_out_if
    import ifp_pkg::*;
;
    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/ipv4_fragment_planner_unit.sv */
// IPv4 fragmentation planner for packets with a 20-byte header. Each word on req
// yields exactly one word on rsp: a start word plans a packet (whole pass, error,
// or first fragment); each next word returns the following fragment, or ST_NONE
// if no packet is pending. An accepted word waits in the input register until
// the result register can take its result; one word is accepted every cycle as
// long as rsp keeps up. The input and result registers each hold one word, so
// one more word is taken while a result waits; after that req stalls until rsp
// takes the waiting result. The link MTU resets to 1500 and the user writes it
// via cfg_wr_en/cfg_wr_data only while the block is idle; it is not enforced.
module ipv4_fragment_planner_unit
    import ifp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    ifp_in_if.sink      req,
    ifp_out_if.source   rsp
);

    logic       held_valid;
    in_word_t   held_word;
    logic       slot_free;
    logic       fire;
    out_word_t  result;
    core_stat_t stat;

    // A held word is processed when the result slot can take its result.
    assign fire = held_valid && slot_free;

    ifp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .take       (fire),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    ifp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .word        (held_word),
        .result      (result),
        .stat        (stat)
    );

    ifp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .word      (result),
        .slot_free (slot_free),
        .rsp       (rsp)
    );

`ifndef SYNTH
    // A fragment that is not the last leaves the packet pending.
    a_pending_set: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.status == ST_OK && !result.last |=> stat.pending)
        else $error("fragment run not left pending");

    // An error or a last fragment ends any pending run.
    a_pending_clr: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (result.status != ST_OK || result.last) |=> !stat.pending)
        else $error("pending run not closed");

    // A local start consumes exactly one identifier.
    a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
        fire && held_word.cmd == CMD_START && !held_word.forwarding
        |=> stat.id_count == $past(stat.id_count) + 16'd1)
        else $error("identifier counter did not advance");

    // Error results carry zero fields.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.status != ST_OK
        |-> rsp.data.frag_len == 16'd0 && rsp.data.ident_out == 16'd0
            && rsp.data.last == 1'b0)
        else $error("error result with nonzero fields");
`endif

endmodule

/* sv/ifp_in_reg.sv */
module ifp_in_reg
    import ifp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ifp_in_if.sink    req,
    input  logic      take,
    output logic      held_valid,
    output in_word_t  held_word
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     load;

    // The register frees up in the same cycle its word is consumed.
    assign req.ready = !valid_reg || take;
    assign load      = req.valid && req.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= req.data;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

/* sv/ifp_core.sv */
module ifp_core
    import ifp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        fire,
    input  in_word_t    word,
    output out_word_t   result,
    output core_stat_t  stat
);

    logic [15:0] link_mtu_reg;
    logic [15:0] id_count_reg;
    logic [15:0] id_count_next;
    logic        pending_reg;
    logic        pending_next;
    logic [15:0] next_off_reg;
    logic [15:0] next_off_next;
    logic [15:0] total_reg;
    logic [15:0] chunk_reg;
    logic [12:0] base_off_reg;
    logic        base_more_reg;
    logic [15:0] ident_reg;

    logic        is_start;
    logic [15:0] s_ident;
    logic        s_more;
    logic [12:0] s_offset;
    logic        too_big;
    logic        plan;
    logic [15:0] s_chunk;
    logic [15:0] s_total;

    logic [15:0] e_off;
    logic [15:0] e_chunk;
    logic [15:0] e_total;
    logic [12:0] e_base;
    logic        e_more;
    logic [15:0] e_ident;
    logic [16:0] e_sum;
    logic        e_fin;
    logic [15:0] e_len;
    out_word_t   frag;

    assign is_start = (word.cmd == CMD_START);

    // Local packets take a fresh identifier and lose MF and offset.
    assign s_ident  = word.forwarding ? word.ident_in : id_count_reg;
    assign s_more   = word.forwarding ? word.more_in : 1'b0;
    assign s_offset = word.forwarding ? word.offset_in : 13'd0;

    assign too_big = (word.total_len > link_mtu_reg);
    assign plan    = too_big && !word.broadcast && !word.dont_fragment
                     && (link_mtu_reg >= MIN_MTU);
    assign s_chunk = (link_mtu_reg - HDR_BYTES) & ALIGN_MASK;
    // A packet shorter than its header has an empty payload.
    assign s_total = (word.total_len >= HDR_BYTES) ? (word.total_len - HDR_BYTES) : 16'd0;

    // Fragment slice: a start takes the new plan, a next takes the held one.
    assign e_off   = is_start ? 16'd0 : next_off_reg;
    assign e_chunk = is_start ? s_chunk : chunk_reg;
    assign e_total = is_start ? s_total : total_reg;
    assign e_base  = is_start ? s_offset : base_off_reg;
    assign e_more  = is_start ? s_more : base_more_reg;
    assign e_ident = is_start ? s_ident : ident_reg;

    assign e_sum = {1'b0, e_off} + {1'b0, e_chunk};
    assign e_fin = (e_sum >= {1'b0, e_total});
    assign e_len = e_fin ? (e_total - e_off) : e_chunk;

    always_comb
    begin
        frag.status      = ST_OK;
        frag.frag_len    = e_len + HDR_BYTES;
        frag.frag_offset = e_base + e_off[15:3];
        frag.more_out    = e_fin ? e_more : 1'b1;
        frag.ident_out   = e_ident;
        frag.last        = e_fin;
    end

    // Result selection in check order.
    always_comb
    begin
        result = '0;
        if (is_start)
        begin
            if (word.broadcast && too_big)
            begin
                result.status = ST_BCAST_BIG;
            end
            else if (!too_big)
            begin
                result.status      = ST_OK;
                result.frag_len    = word.total_len;
                result.frag_offset = s_offset;
                result.more_out    = s_more;
                result.ident_out   = s_ident;
                result.last        = 1'b1;
            end
            else if (word.dont_fragment)
            begin
                result.status = ST_DF_SET;
            end
            else if (link_mtu_reg < MIN_MTU)
            begin
                result.status = ST_MTU_SMALL;
            end
            else
            begin
                result = frag;
            end
        end
        else if (!pending_reg)
        begin
            result.status = ST_NONE;
        end
        else
        begin
            result = frag;
        end
    end

    // Next values of the control state.
    always_comb
    begin
        id_count_next = id_count_reg;
        pending_next  = pending_reg;
        next_off_next = next_off_reg;
        if (fire)
        begin
            if (is_start)
            begin
                if (!word.forwarding)
                begin
                    id_count_next = id_count_reg + 16'd1;
                end
                pending_next  = plan && !e_fin;
                next_off_next = e_sum[15:0];
            end
            else if (pending_reg)
            begin
                pending_next  = !e_fin;
                next_off_next = e_sum[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_mtu_reg <= MTU_RESET;
            id_count_reg <= '0;
            pending_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                link_mtu_reg <= cfg_wr_data;
            end
            id_count_reg <= id_count_next;
            pending_reg  <= pending_next;
        end
    end

    // Plan registers are only read while a packet is pending.
    always_ff @(posedge clk)
    begin
        next_off_reg <= next_off_next;
        if (fire && is_start && plan)
        begin
            total_reg     <= s_total;
            chunk_reg     <= s_chunk;
            base_off_reg  <= s_offset;
            base_more_reg <= s_more;
            ident_reg     <= s_ident;
        end
    end

    assign stat.pending  = pending_reg;
    assign stat.id_count = id_count_reg;

endmodule

/* sv/ifp_out_reg.sv */
module ifp_out_reg
    import ifp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_word_t word,
    output logic      slot_free,
    ifp_out_if.source rsp
);

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    // A new result may enter when the slot is empty or being drained.
    assign slot_free = !valid_reg || rsp.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word;
        end
    end

    assign rsp.valid = valid_reg;
    assign rsp.data  = word_reg;

endmodule
